@@ hw/rtl/rfa_pkg.sv @@
// Package for the rational fraction ALU: widths, codes, command and status types.
// Shared by rfa_div, rfa_dp, rfa_ctrl and rational_fraction_alu_top; depends on nothing.
package rfa_pkg;

    // Arithmetic width; operands are the low VALUE_WIDTH bits of each field
    localparam int VALUE_WIDTH = 32;
    localparam int W           = VALUE_WIDTH;
    localparam int CNT_W       = $clog2(W);

    // Field widths and stream packing
    localparam int OP_W        = 3;
    localparam int FIELD_W     = 32;
    localparam int ST_W        = 2;
    localparam int IN_BITS     = OP_W + 4 * FIELD_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 2 * FIELD_W + ST_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Input field offsets in tdata
    localparam int OFS_OP   = 0;
    localparam int OFS_A_NUM = OFS_OP + OP_W;
    localparam int OFS_A_DEN = OFS_A_NUM + FIELD_W;
    localparam int OFS_B_NUM = OFS_A_DEN + FIELD_W;
    localparam int OFS_B_DEN = OFS_B_NUM + FIELD_W;

    typedef logic signed [W-1:0]   t_val;
    typedef logic        [W-1:0]   t_mag;
    typedef logic signed [2*W-1:0] t_prod;
    typedef logic signed [FIELD_W-1:0] t_field;

    // Operation codes; codes above OP_RED behave as reduce
    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_RED = 3'd4
    } t_op;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_GCD_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL0,
        DP_MUL1,
        DP_MUL2,
        DP_COMBINE,
        DP_DIV_XY,
        DP_STEP_XY,
        DP_DIV_NUM,
        DP_NUM_DONE,
        DP_KEEP_QD,
        DP_SET_OVF,
        DP_SET_ZERO
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic ovf;
        logic x_zero;
        logic y_zero;
        logic div_done;
    } t_dp_stat;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_COMBINE,
        S_TEST,
        S_GCD_WAIT,
        S_QN_WAIT,
        S_QD_WAIT,
        S_DONE
    } t_state;

    // Magnitude of a signed value; the most negative value maps to 2^(W-1)
    function automatic t_mag mag(input t_val v);
        t_mag r;
        r = v[W-1] ? t_mag'(~v + 1'b1) : t_mag'(v);
        return r;
    endfunction

    // Product fits in W bits signed when its top W+1 bits all agree
    function automatic logic prod_fits(input t_prod p);
        logic fit;
        fit = (&p[2*W-1:W-1]) | ~(|p[2*W-1:W-1]);
        return fit;
    endfunction

endpackage

@@ hw/rtl/rational_fraction_alu_top.sv @@
// Top level of the rational fraction ALU: controller and datapath joined by command/status.
// Depends on rfa_pkg, rfa_ctrl, rfa_dp (which holds rfa_div).
//
//  Channel   Direction  Fields in tdata (low bit first)
//  s_axis    in         op[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99]
//  m_axis    out        res_num[31:0], res_den[63:32], status[65:64]
//
// An item runs through the three products and their combination, then Euclid
// remainder steps plus two final divisions of numerator and denominator by the gcd,
// each a division on the one-bit-per-cycle divider.
// Reset (i_rst_n low, synchronous) returns the controller to idle and drops m_axis valid.
// A new item is taken while a finished result still waits in the output register;
// a stalled m_axis holds the next result in the controller until the register frees.
module rational_fraction_alu_top import rfa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // op, a_num, a_den, b_num, b_den, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // res_num, res_den, status, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rfa_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    rfa_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_tdata (i_s_axis_tdata),
        .o_stat  (stat),
        .o_tdata (o_m_axis_tdata)
    );

endmodule

@@ hw/rtl/rfa_div.sv @@
// Iterative signed divider with truncated quotient and remainder, one bit per cycle.
// Depends on rfa_pkg; used by rfa_dp for Euclid remainders and the final reductions.
module rfa_div import rfa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_val i_dividend,
    input  t_val i_divisor,
    output logic o_done,
    output t_val o_quo,
    output t_val o_rem,
    output logic o_quo_ovf
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt;
    t_mag             r_rem;
    t_mag             r_quo;
    t_mag             r_dmag;
    logic             r_qneg;
    logic             r_rneg;

    logic [W:0] rem_sh;
    logic [W:0] diff;
    logic       take;
    t_mag       quo_s;
    t_mag       rem_s;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign rem_sh = {r_rem, r_quo[W-1]};
    assign diff   = rem_sh - {1'b0, r_dmag};
    assign take   = ~diff[W];

    // Busy and done flags
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (r_busy && (r_cnt == CNT_W'(W - 1))) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Operand load and iteration
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= mag(i_dividend);
            r_dmag <= mag(i_divisor);
            r_qneg <= i_dividend[W-1] ^ i_divisor[W-1];
            r_rneg <= i_dividend[W-1];
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_rem <= take ? diff[W-1:0] : rem_sh[W-1:0];
            r_quo <= {r_quo[W-2:0], take};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Restore signs: quotient by sign difference, remainder follows the dividend
    assign quo_s     = r_qneg ? (~r_quo + 1'b1) : r_quo;
    assign rem_s     = r_rneg ? (~r_rem + 1'b1) : r_rem;
    assign o_quo     = signed'(quo_s);
    assign o_rem     = signed'(rem_s);
    assign o_quo_ovf = ~r_qneg & r_quo[W-1];
    assign o_done    = r_done;

endmodule

@@ hw/rtl/rfa_dp.sv @@
// Datapath of the rational fraction ALU: operand registers, shared multiplier,
// Euclid registers, divider and result register. Depends on rfa_pkg and rfa_div.
module rfa_dp import rfa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic [IN_TDATA_W-1:0]  i_tdata,
    output t_dp_stat               o_stat,
    output logic [OUT_TDATA_W-1:0] o_tdata
);

    t_op     r_op;
    t_val    r_an, r_ad, r_bn, r_bd;
    t_prod   r_p1, r_p2, r_p3;
    logic    r_ovf;
    t_val    r_num, r_den;
    t_val    r_x, r_y;
    t_val    r_qn, r_qd;
    logic    r_qovf;
    t_status r_st;
    t_field  r_out_num, r_out_den;
    t_status r_out_st;

    t_val    mul_a, mul_b;
    t_prod   prod;
    logic signed [W:0] sum;
    logic    is_mul;
    logic    div_start;
    t_val    div_dvd, div_dvs;
    logic    div_done;
    t_val    div_quo, div_rem;
    logic    div_qovf;

    assign is_mul = (r_op == OP_MUL);

    // Select multiplier operands per step and operation
    always_comb begin
        mul_a = r_an;
        mul_b = r_bd;
        unique case (i_cmd.op)
            DP_MUL0: begin
                mul_a = r_an;
                mul_b = is_mul ? r_bn : r_bd;
            end
            DP_MUL1: begin
                mul_a = r_ad;
                mul_b = is_mul ? r_bd : r_bn;
            end
            DP_MUL2: begin
                mul_a = r_ad;
                mul_b = r_bd;
            end
            default: begin
                mul_a = r_an;
                mul_b = r_bd;
            end
        endcase
    end

    // Signed W by W product, sign-extended to the full product width
    assign prod = t_prod'(mul_a) * t_prod'(mul_b);

    // Sum or difference of the cross products, one bit of headroom
    always_comb begin
        if (r_op == OP_ADD) begin
            sum = (W+1)'(signed'(r_p1[W-1:0])) + (W+1)'(signed'(r_p2[W-1:0]));
        end else begin
            sum = (W+1)'(signed'(r_p1[W-1:0])) - (W+1)'(signed'(r_p2[W-1:0]));
        end
    end

    // Divider operand selection
    always_comb begin
        div_start = 1'b0;
        div_dvd   = r_x;
        div_dvs   = r_y;
        unique case (i_cmd.op)
            DP_DIV_XY: begin
                div_start = 1'b1;
                div_dvd   = r_x;
                div_dvs   = r_y;
            end
            DP_DIV_NUM: begin
                div_start = 1'b1;
                div_dvd   = r_num;
                div_dvs   = r_x;
            end
            DP_NUM_DONE: begin
                div_start = 1'b1;
                div_dvd   = r_den;
                div_dvs   = r_x;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    rfa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem),
        .o_quo_ovf  (div_qovf)
    );

    // Datapath registers, advanced by controller command
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_op <= t_op'(i_tdata[OFS_OP +: OP_W]);
                r_an <= signed'(i_tdata[OFS_A_NUM +: W]);
                r_ad <= signed'(i_tdata[OFS_A_DEN +: W]);
                r_bn <= signed'(i_tdata[OFS_B_NUM +: W]);
                r_bd <= signed'(i_tdata[OFS_B_DEN +: W]);
            end
            DP_MUL0: r_p1 <= prod;
            DP_MUL1: r_p2 <= prod;
            DP_MUL2: r_p3 <= prod;
            DP_COMBINE: begin
                unique case (r_op)
                    OP_ADD, OP_SUB: begin
                        r_ovf <= ~prod_fits(r_p1) | ~prod_fits(r_p2) | ~prod_fits(r_p3)
                                 | (sum[W] != sum[W-1]);
                        r_num <= sum[W-1:0];
                        r_den <= r_p3[W-1:0];
                        r_x   <= sum[W-1:0];
                        r_y   <= r_p3[W-1:0];
                    end
                    OP_MUL, OP_DIV: begin
                        r_ovf <= ~prod_fits(r_p1) | ~prod_fits(r_p2);
                        r_num <= r_p1[W-1:0];
                        r_den <= r_p2[W-1:0];
                        r_x   <= r_p1[W-1:0];
                        r_y   <= r_p2[W-1:0];
                    end
                    default: begin
                        r_ovf <= 1'b0;
                        r_num <= r_an;
                        r_den <= r_ad;
                        r_x   <= r_an;
                        r_y   <= r_ad;
                    end
                endcase
            end
            DP_STEP_XY: begin
                r_x <= r_y;
                r_y <= div_rem;
            end
            DP_NUM_DONE: begin
                r_qn   <= div_quo;
                r_qovf <= div_qovf;
            end
            DP_KEEP_QD: begin
                r_qd <= div_quo;
                r_st <= (r_qovf | div_qovf) ? ST_OVERFLOW : ST_OK;
            end
            DP_SET_OVF:  r_st <= ST_OVERFLOW;
            DP_SET_ZERO: r_st <= ST_GCD_ZERO;
            default: begin
            end
        endcase
    end

    // Output register; fields read zero unless the status is ok
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_st <= r_st;
            if (r_st == ST_OK) begin
                r_out_num <= FIELD_W'(r_qn);
                r_out_den <= FIELD_W'(r_qd);
            end else begin
                r_out_num <= '0;
                r_out_den <= '0;
            end
        end
    end

    assign o_tdata = OUT_TDATA_W'({r_out_st, r_out_den, r_out_num});

    assign o_stat.ovf      = r_ovf;
    assign o_stat.x_zero   = (r_x == '0);
    assign o_stat.y_zero   = (r_y == '0);
    assign o_stat.div_done = div_done;

endmodule

@@ hw/rtl/rfa_ctrl.sv @@
// Controller of the rational fraction ALU: sequences products, Euclid and reduction
// and runs both stream handshakes. Depends on rfa_pkg.
module rfa_ctrl import rfa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_axis_tvalid,
    output logic     o_s_axis_tready,
    output logic     o_m_axis_tvalid,
    input  logic     i_m_axis_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state         = r_state;
        n_m_valid       = r_m_valid;
        o_cmd.op        = DP_NOP;
        o_cmd.out_load  = 1'b0;
        o_s_axis_tready = 1'b0;

        // Drop valid once the pending result is taken
        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_MUL0;
                end
            end
            S_MUL0: begin
                o_cmd.op = DP_MUL0;
                n_state  = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.op = DP_MUL1;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.op = DP_MUL2;
                n_state  = S_COMBINE;
            end
            S_COMBINE: begin
                o_cmd.op = DP_COMBINE;
                n_state  = S_TEST;
            end
            // Decide: overflow, zero gcd, gcd found, or another remainder step
            S_TEST: begin
                if (i_stat.ovf) begin
                    o_cmd.op = DP_SET_OVF;
                    n_state  = S_DONE;
                end else if (i_stat.y_zero) begin
                    if (i_stat.x_zero) begin
                        o_cmd.op = DP_SET_ZERO;
                        n_state  = S_DONE;
                    end else begin
                        o_cmd.op = DP_DIV_NUM;
                        n_state  = S_QN_WAIT;
                    end
                end else begin
                    o_cmd.op = DP_DIV_XY;
                    n_state  = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = DP_STEP_XY;
                    n_state  = S_TEST;
                end
            end
            S_QN_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = DP_NUM_DONE;
                    n_state  = S_QD_WAIT;
                end
            end
            S_QD_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = DP_KEEP_QD;
                    n_state  = S_DONE;
                end
            end
            // Hold the result until the output register is free
            S_DONE: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_m_valid;

endmodule
